// ===== rtl/core/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation unit.
// Used by the controller, the datapath and the top level; no dependencies.

package mexp_pkg;

   // Fixed widths of the transaction fields.
   localparam int BASE_WIDTH    = 63;
   localparam int EXP_WIDTH     = 63;
   localparam int MOD_WIDTH     = 32;
   localparam int RESULT_WIDTH  = 32;

   // Default for the usable modulus width (range 8 to 32).
   localparam int DEFAULT_MODULUS_WIDTH = 32;

   // The reduction shift register holds the zero-extended base or a product.
   localparam int DIV_WIDTH = BASE_WIDTH + 1;
   // The reducer retires two dividend bits per cycle.
   localparam int BASE_RED_STEPS = DIV_WIDTH / 2;
   localparam int CNT_WIDTH = $clog2(BASE_RED_STEPS + 1);

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_BASE_RED,
      ST_CHECK,
      ST_MUL_ACC,
      ST_ACC_RED,
      ST_MUL_SQR,
      ST_SQR_RED,
      ST_FINISH
   } mexp_state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_RED_STEP,
      DP_BASE_STORE,
      DP_MUL_ACC,
      DP_MUL_SQR,
      DP_ACC_STORE,
      DP_SQR_STORE,
      DP_OUT_WRITE
   } mexp_op_type;

   typedef struct packed {
      mexp_op_type op;
   } mexp_cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic exp_zero;
      logic exp_lsb;
      logic red_done;
      logic out_free;
   } mexp_status_type;

endpackage

// ===== rtl/core/mexp_datapath.sv =====
// Datapath of the modular exponentiation unit: operand registers, one shared
// multiplier, a two-bit-per-cycle remainder unit and the result register.
// Depends on mexp_pkg.

module mexp_datapath import mexp_pkg::*; #(
   parameter int MODULUS_WIDTH = DEFAULT_MODULUS_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mexp_cmd_type            cmd,
   output mexp_status_type         status,
   input  logic [BASE_WIDTH-1:0]   req_base_value,
   input  logic [EXP_WIDTH-1:0]    req_exponent,
   input  logic [MOD_WIDTH-1:0]    req_modulus,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [RESULT_WIDTH-1:0] rsp_power_result,
   output logic                    rsp_zero_modulus_error
);

   localparam int MW = MODULUS_WIDTH;
   localparam int PW = 2 * MODULUS_WIDTH;

   logic [MW-1:0]        mod_ff, mod_in;
   logic [MW-1:0]        base_ff, base_in;
   logic [MW-1:0]        acc_ff, acc_in;
   logic [EXP_WIDTH-1:0] exp_ff, exp_in;
   logic [DIV_WIDTH-1:0] div_ff, div_in;
   logic [MW-1:0]        rem_ff, rem_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] result_ff, result_in;
   logic                    error_ff, error_in;

   logic [MW-1:0] mul_a;
   logic [PW-1:0] product;
   logic [MW:0]   trial1, trial2;
   logic [MW-1:0] rem1, rem2;

   // Shared multiplier; its product is registered in the dividend register.
   assign mul_a   = (cmd.op == DP_MUL_ACC) ? acc_ff : base_ff;
   assign product = PW'(mul_a) * PW'(base_ff);

   // Two restoring remainder steps, most significant dividend bits first.
   always_comb begin
      trial1 = {rem_ff, div_ff[DIV_WIDTH-1]};
      if (trial1 >= {1'b0, mod_ff}) begin
         rem1 = MW'(trial1 - {1'b0, mod_ff});
      end else begin
         rem1 = trial1[MW-1:0];
      end
      trial2 = {rem1, div_ff[DIV_WIDTH-2]};
      if (trial2 >= {1'b0, mod_ff}) begin
         rem2 = MW'(trial2 - {1'b0, mod_ff});
      end else begin
         rem2 = trial2[MW-1:0];
      end
   end

   // Next values of the working registers.
   always_comb begin
      mod_in  = mod_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      exp_in  = exp_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      result_in = result_ff;
      error_in  = error_ff;
      case (cmd.op)
         DP_LOAD: begin
            mod_in = req_modulus[MW-1:0];
            exp_in = req_exponent;
            acc_in = MW'(1);
            div_in = {1'b0, req_base_value};
            rem_in = '0;
            cnt_in = CNT_WIDTH'(BASE_RED_STEPS);
         end
         DP_RED_STEP: begin
            rem_in = rem2;
            div_in = div_ff << 2;
            cnt_in = cnt_ff - CNT_WIDTH'(1);
         end
         DP_BASE_STORE: begin
            base_in = rem_ff;
         end
         DP_MUL_ACC, DP_MUL_SQR: begin
            div_in = DIV_WIDTH'(product) << (DIV_WIDTH - PW);
            rem_in = '0;
            cnt_in = CNT_WIDTH'(MW);
         end
         DP_ACC_STORE: begin
            acc_in = rem_ff;
         end
         DP_SQR_STORE: begin
            base_in = rem_ff;
            exp_in  = exp_ff >> 1;
         end
         DP_OUT_WRITE: begin
            error_in = (mod_ff == '0);
            if (mod_ff == '0) begin
               result_in = '0;
            end else begin
               result_in = RESULT_WIDTH'(acc_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Result valid: set on a write, cleared once the transaction is taken.
   always_comb begin
      if (cmd.op == DP_OUT_WRITE) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_ff    <= mod_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      exp_ff    <= exp_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
      error_ff  <= error_in;
   end

   // Status back to the controller.
   always_comb begin
      status.mod_zero = (mod_ff == '0);
      status.exp_zero = (exp_ff == '0);
      status.exp_lsb  = exp_ff[0];
      status.red_done = (cnt_ff == '0);
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_power_result       = result_ff;
   assign rsp_zero_modulus_error = error_ff;

endmodule

// ===== rtl/core/mexp_ctrl.sv =====
// Controller of the modular exponentiation unit: sequences base reduction
// and the square-and-multiply loop over the datapath. Depends on mexp_pkg.

module mexp_ctrl import mexp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  mexp_status_type status,
   output mexp_cmd_type    cmd
);

   mexp_state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.mod_zero || status.exp_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_BASE_RED;
            end
         end
         ST_BASE_RED: begin
            if (status.red_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.exp_zero) begin
               state_in = ST_FINISH;
            end else if (status.exp_lsb) begin
               state_in = ST_MUL_ACC;
            end else begin
               state_in = ST_MUL_SQR;
            end
         end
         ST_MUL_ACC: begin
            state_in = ST_ACC_RED;
         end
         ST_ACC_RED: begin
            if (status.red_done) begin
               state_in = ST_MUL_SQR;
            end
         end
         ST_MUL_SQR: begin
            state_in = ST_SQR_RED;
         end
         ST_SQR_RED: begin
            if (status.red_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath commands and input handshake.
   always_comb begin
      cmd.op    = DP_NOP;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = DP_LOAD;
            end
         end
         ST_BASE_RED: begin
            cmd.op = status.red_done ? DP_BASE_STORE : DP_RED_STEP;
         end
         ST_MUL_ACC: begin
            cmd.op = DP_MUL_ACC;
         end
         ST_ACC_RED: begin
            cmd.op = status.red_done ? DP_ACC_STORE : DP_RED_STEP;
         end
         ST_MUL_SQR: begin
            cmd.op = DP_MUL_SQR;
         end
         ST_SQR_RED: begin
            cmd.op = status.red_done ? DP_SQR_STORE : DP_RED_STEP;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.op = DP_OUT_WRITE;
            end
         end
         default: begin
            cmd.op = DP_NOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/modular_exponentiation_unit.sv =====
// Modular exponentiation unit: returns base ** exponent mod modulus by
// right-to-left square-and-multiply, one transaction at a time. Only the low
// MODULUS_WIDTH bits of the modulus are used. A zero modulus gives a result
// of 0 with the error flag set; a zero exponent gives 1, also for a modulus
// of one. After an operand check the base is reduced, then each exponent bit
// up to the highest set one costs a squaring, preceded by a multiply into the
// accumulator when the bit is set; every modular product goes through one
// shared reducer that retires two product bits per cycle. A finished result
// waits in an output register while the next transaction is taken.
// Depends on mexp_pkg, mexp_ctrl and mexp_datapath.

module modular_exponentiation_unit import mexp_pkg::*; #(
   parameter int MODULUS_WIDTH = DEFAULT_MODULUS_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [BASE_WIDTH-1:0]   req_base_value,
   input  logic [EXP_WIDTH-1:0]    req_exponent,
   input  logic [MOD_WIDTH-1:0]    req_modulus,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [RESULT_WIDTH-1:0] rsp_power_result,
   output logic                    rsp_zero_modulus_error
);

   mexp_cmd_type    cmd;
   mexp_status_type status;

   // Sequencer.
   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and result register.
   mexp_datapath #(
      .MODULUS_WIDTH (MODULUS_WIDTH)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_base_value         (req_base_value),
      .req_exponent           (req_exponent),
      .req_modulus            (req_modulus),
      .rsp_stall              (rsp_stall),
      .rsp_valid              (rsp_valid),
      .rsp_power_result       (rsp_power_result),
      .rsp_zero_modulus_error (rsp_zero_modulus_error)
   );

endmodule

// ===== bench/mexp_result_check.sv =====
// Result checker for the modular exponentiation unit: predicts each result from
// the accepted request transactions and compares it with the result channel.
// Depends on mexp_pkg for the field widths.

module mexp_result_check import mexp_pkg::*; #(
   parameter int MODULUS_BITS = DEFAULT_MODULUS_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [BASE_WIDTH-1:0]   req_base_value,
   input  logic [EXP_WIDTH-1:0]    req_exponent,
   input  logic [MOD_WIDTH-1:0]    req_modulus,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [RESULT_WIDTH-1:0] rsp_power_result,
   input  logic                    rsp_zero_modulus_error,
   output int                      mismatch_count,
   output int                      pending_count,
   output int                      checked_count
);

   typedef struct packed {
      logic [RESULT_WIDTH-1:0] power_result;
      logic                    zero_modulus_error;
   } power_outcome_type;

   // Right-to-left square-and-multiply on 64-bit values; every factor stays
   // below a 32-bit modulus, so no product overflows.
   function automatic power_outcome_type expected_power(
      input logic [BASE_WIDTH-1:0] base_in,
      input logic [EXP_WIDTH-1:0]  exp_in,
      input logic [MOD_WIDTH-1:0]  mod_in
   );
      logic [63:0]          modulus;
      logic [63:0]          square;
      logic [63:0]          running;
      logic [EXP_WIDTH-1:0] bits_left;
      power_outcome_type    outcome;
      modulus = 64'(mod_in);
      modulus = modulus & ((64'd1 << MODULUS_BITS) - 64'd1);
      if (modulus == 64'd0) begin
         outcome.power_result       = '0;
         outcome.zero_modulus_error = 1'b1;
         return outcome;
      end
      // A zero exponent leaves the running product at 1, even for a modulus of one.
      running   = 64'd1;
      square    = {1'b0, base_in} % modulus;
      bits_left = exp_in;
      while (bits_left != '0) begin
         if (bits_left[0]) begin
            running = (running * square) % modulus;
         end
         square    = (square * square) % modulus;
         bits_left = bits_left >> 1;
      end
      outcome.power_result       = running[RESULT_WIDTH-1:0];
      outcome.zero_modulus_error = 1'b0;
      return outcome;
   endfunction

   power_outcome_type pending_powers[$];
   int                mismatches = 0;
   int                checked    = 0;

   // Results are matched first, so a request taken at the same edge is never
   // mistaken for the one being answered.
   always @(posedge clock) begin
      power_outcome_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_powers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: result %h flag %b arrived with no request outstanding",
                           $time, rsp_power_result, rsp_zero_modulus_error);
               end
            end else begin
               want = pending_powers.pop_front();
               checked++;
               if (want.power_result !== rsp_power_result ||
                   want.zero_modulus_error !== rsp_zero_modulus_error) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch, expected result %h flag %b, got result %h flag %b",
                              $time, want.power_result, want.zero_modulus_error,
                              rsp_power_result, rsp_zero_modulus_error);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_powers.push_back(expected_power(req_base_value, req_exponent,
                                                    req_modulus));
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= pending_powers.size();
      checked_count  <= checked;
   end

endmodule

// ===== bench/tb_modular_exponentiation_unit.sv =====
// Testbench top for the modular exponentiation unit: drives directed and random
// request transactions with random gaps and result stalls, and gives the verdict.
// Depends on mexp_pkg, modular_exponentiation_unit and mexp_result_check.

module tb_modular_exponentiation_unit;
   import mexp_pkg::*;

   localparam int                  MOD_BITS     = DEFAULT_MODULUS_WIDTH;
   localparam int                  RANDOM_ITEMS = 120;
   localparam logic [EXP_WIDTH-1:0] ALL_ONES    = '1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [BASE_WIDTH-1:0]   req_base_value = '0;
   logic [EXP_WIDTH-1:0]    req_exponent = '0;
   logic [MOD_WIDTH-1:0]    req_modulus = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [RESULT_WIDTH-1:0] rsp_power_result;
   logic                    rsp_zero_modulus_error;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int sent_count     = 0;
   int directed_count = 0;
   int zero_mod_count = 0;
   int wide_exp_count = 0;

   modular_exponentiation_unit #(
      .MODULUS_WIDTH(MOD_BITS)
   ) u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_base_value         (req_base_value),
      .req_exponent           (req_exponent),
      .req_modulus            (req_modulus),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_power_result       (rsp_power_result),
      .rsp_zero_modulus_error (rsp_zero_modulus_error)
   );

   mexp_result_check #(
      .MODULUS_BITS(MOD_BITS)
   ) u_result_check (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_base_value         (req_base_value),
      .req_exponent           (req_exponent),
      .req_modulus            (req_modulus),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_power_result       (rsp_power_result),
      .rsp_zero_modulus_error (rsp_zero_modulus_error),
      .mismatch_count         (mismatch_count),
      .pending_count          (pending_count),
      .checked_count          (checked_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #50_000_000;
      $display("tb_modular_exponentiation_unit: done, errors");
      $finish;
   end

   // Idle length between transactions: mostly short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 120);
   endfunction

   function automatic logic [EXP_WIDTH-1:0] rand63();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[EXP_WIDTH-1:0];
   endfunction

   // The result side stalls in bursts, with long quiet stretches now and then.
   initial begin
      int roll;
      int run;
      @(posedge clock);
      forever begin
         roll = $urandom_range(0, 99);
         run  = (roll < 15) ? $urandom_range(100, 400) : $urandom_range(0, 12);
         repeat (run) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
         roll = $urandom_range(0, 99);
         if (roll < 70) run = $urandom_range(1, 3);
         else if (roll < 95) run = $urandom_range(4, 20);
         else run = $urandom_range(40, 150);
         repeat (run) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Presents one request transaction and returns at the edge that accepts it.
   // Valid is only lowered when a gap follows, so back-to-back items keep it high.
   task automatic send_request(input logic [BASE_WIDTH-1:0] base_in,
                               input logic [EXP_WIDTH-1:0]  exp_in,
                               input logic [MOD_WIDTH-1:0]  mod_in,
                               input int                    gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_base_value <= base_in;
      req_exponent   <= exp_in;
      req_modulus    <= mod_in;
      do @(posedge clock); while (req_stall);
      sent_count++;
      if (mod_in == '0) zero_mod_count++;
      if (exp_in[EXP_WIDTH-1]) wide_exp_count++;
   endtask

   // Random request: exponents are mostly short to keep the run brief,
   // with one in ten spanning all 63 bits.
   task automatic make_random_request(output logic [BASE_WIDTH-1:0] base_out,
                                      output logic [EXP_WIDTH-1:0]  exp_out,
                                      output logic [MOD_WIDTH-1:0]  mod_out);
      int roll;
      int exp_bits;
      roll = $urandom_range(0, 99);
      if (roll < 8) exp_bits = 0;
      else if (roll < 68) exp_bits = $urandom_range(1, 12);
      else if (roll < 90) exp_bits = $urandom_range(13, 32);
      else exp_bits = EXP_WIDTH;
      exp_out = (exp_bits == 0) ? '0 : rand63() & (ALL_ONES >> (EXP_WIDTH - exp_bits));

      roll = $urandom_range(0, 99);
      if (roll < 4) mod_out = '0;
      else if (roll < 8) mod_out = 32'd1;
      else if (roll < 35) mod_out = $urandom_range(2, 255);
      else if (roll < 65) mod_out = $urandom;
      else if (roll < 85) mod_out = $urandom | 32'h8000_0000;
      else mod_out = 32'hFFFF_FFFF - $urandom_range(0, 64);

      roll = $urandom_range(0, 99);
      if (roll < 50) base_out = rand63();
      else if (roll < 75) base_out = BASE_WIDTH'($urandom);
      else base_out = BASE_WIDTH'($urandom_range(0, 300));
   endtask

   // Stimulus and verdict.
   initial begin
      logic [BASE_WIDTH-1:0] base_pick;
      logic [EXP_WIDTH-1:0]  exp_pick;
      logic [MOD_WIDTH-1:0]  mod_pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero modulus, zero exponent, modulus of one and the
      // extremes of every field.
      send_request('0, '0, '0, pick_gap());
      send_request(ALL_ONES, ALL_ONES, '0, pick_gap());
      send_request(63'd5, '0, 32'd1, pick_gap());
      send_request('0, '0, 32'd7, pick_gap());
      send_request(ALL_ONES, 63'd5, 32'd1, pick_gap());
      send_request('0, 63'd1, 32'd13, pick_gap());
      send_request('0, ALL_ONES, 32'hFFFF_FFFF, pick_gap());
      send_request(ALL_ONES, ALL_ONES, 32'hFFFF_FFFF, pick_gap());
      send_request(ALL_ONES, 63'd1, 32'hFFFF_FFFF, pick_gap());
      send_request(63'd2, 63'd62, 32'hFFFF_FFFB, pick_gap());
      send_request(63'd3, ALL_ONES, 32'h8000_0000, pick_gap());
      send_request(63'hFFFF_FFFF, 63'd2, 32'hFFFF_FFFF, pick_gap());
      send_request(63'h1_0000_0000, 63'd3, 32'hFFFF_FFFF, pick_gap());
      send_request(63'hFFFF_FFFA, 63'h1000_0000_0000, 32'hFFFF_FFFB, pick_gap());
      send_request(63'd7, 63'h4000_0000_0000_0000, 32'd1_000_003, pick_gap());
      send_request(63'd12345, 63'd65537, 32'hFFFF_FFFB, pick_gap());
      send_request(ALL_ONES, ALL_ONES, 32'd2, pick_gap());
      send_request(63'd1, ALL_ONES, 32'd3, pick_gap());
      send_request(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA,
                   pick_gap());
      send_request(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 32'h5555_5555,
                   pick_gap());
      directed_count = sent_count;

      // Random part, with one stretch of back-to-back requests.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         make_random_request(base_pick, exp_pick, mod_pick);
         send_request(base_pick, exp_pick, mod_pick,
                      (i >= 60 && i < 80) ? 0 : pick_gap());
      end
      req_valid <= 1'b0;

      // Drain: the checker's count is registered, so it lags behind the last acceptance.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Covered %0d requests (%0d directed, %0d random), %0d with zero modulus,",
               sent_count, directed_count, sent_count - directed_count, zero_mod_count);
      $display("%0d with exponent bit 62 set; %0d results compared, %0d mismatches.",
               wide_exp_count, checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_modular_exponentiation_unit: done, clean");
      end else begin
         $display("tb_modular_exponentiation_unit: done, errors");
      end
      $finish;
   end

endmodule
